// ----- sv/sdf_pkg.sv -----
// Shared types and constants for the stencil derivative filter.
// No dependencies; used by every module of the block.
package sdf_pkg;

   localparam int SAMPLE_BITS_DEFAULT    = 16;
   localparam int GAIN_FRAC_BITS_DEFAULT = 16;
   localparam int GAIN_BITS              = 32;
   localparam int ORDER_BITS             = 3;
   localparam int CSR_INDEX_BITS         = 2;
   localparam int CSR_DATA_BITS          = 32;
   localparam int STENCIL_GROWTH         = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_METHOD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ORDER  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN   = 2'd2;

   localparam logic METHOD_SIMPLE = 1'b0;
   localparam logic METHOD_FIVE   = 1'b1;

   localparam logic [ORDER_BITS-1:0] ORDER_FIRST  = 3'd1;
   localparam logic [ORDER_BITS-1:0] ORDER_SECOND = 3'd2;
   localparam logic [ORDER_BITS-1:0] ORDER_THIRD  = 3'd3;
   localparam logic [ORDER_BITS-1:0] ORDER_FOURTH = 3'd4;

   localparam logic                  METHOD_RESET = METHOD_SIMPLE;
   localparam logic [ORDER_BITS-1:0] ORDER_RESET  = ORDER_FIRST;
   localparam logic [GAIN_BITS-1:0]  GAIN_RESET   = 32'h0001_0000;

   typedef struct packed {
      logic                  method;
      logic [ORDER_BITS-1:0] order;
   } stencil_cfg_type;

endpackage

// ----- sv/sdf_stencil.sv -----
// Four-entry sample delay line and the integer stencil sum over five taps.
// Depends on sdf_pkg.
module sdf_stencil #(
   parameter int SAMPLE_BITS = sdf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int SUM_BITS    = SAMPLE_BITS + sdf_pkg::STENCIL_GROWTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic signed [SAMPLE_BITS-1:0] sample,
   input  sdf_pkg::stencil_cfg_type     cfg,
   output logic signed [SUM_BITS-1:0]    sum
);

   logic signed [SAMPLE_BITS-1:0] tap_ff [4];
   logic signed [SUM_BITS-1:0]    x0, x1, x2, x3, x4;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) tap_ff[i] <= '0;
      end else if (accept) begin
         tap_ff[3] <= tap_ff[2];
         tap_ff[2] <= tap_ff[1];
         tap_ff[1] <= tap_ff[0];
         tap_ff[0] <= sample;
      end
   end

   assign x0 = SUM_BITS'(sample);
   assign x1 = SUM_BITS'(tap_ff[0]);
   assign x2 = SUM_BITS'(tap_ff[1]);
   assign x3 = SUM_BITS'(tap_ff[2]);
   assign x4 = SUM_BITS'(tap_ff[3]);

   always_comb begin
      sum = x1 - x3;
      if (cfg.method == sdf_pkg::METHOD_FIVE) begin
         case (cfg.order)
            sdf_pkg::ORDER_FIRST: begin
               sum = (x4 - x0) + ((x1 - x3) <<< 3);
            end
            sdf_pkg::ORDER_SECOND: begin
               sum = ((x1 + x3) <<< 4) - (x0 + x4) - ((x2 <<< 5) - (x2 <<< 1));
            end
            sdf_pkg::ORDER_THIRD: begin
               sum = (x0 - x4) - ((x1 - x3) <<< 1);
            end
            sdf_pkg::ORDER_FOURTH: begin
               sum = (x0 + x4) - ((x1 + x3) <<< 2) + ((x2 <<< 2) + (x2 <<< 1));
            end
            default: begin
               sum = x1 - x3;
            end
         endcase
      end else if (cfg.order == sdf_pkg::ORDER_SECOND) begin
         sum = (x1 + x3) - (x2 <<< 1);
      end
   end

endmodule

// ----- sv/sdf_round.sv -----
// Round-to-nearest of the gain product and saturation to the sample range.
// Depends on sdf_pkg for nothing beyond its widths handed down.
module sdf_round #(
   parameter int SAMPLE_BITS    = sdf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = sdf_pkg::GAIN_FRAC_BITS_DEFAULT,
   parameter int PROD_BITS      = SAMPLE_BITS + sdf_pkg::STENCIL_GROWTH + sdf_pkg::GAIN_BITS
) (
   input  logic signed [PROD_BITS-1:0]   product,
   output logic signed [SAMPLE_BITS-1:0] derivative,
   output logic                          saturated
);

   localparam logic signed [PROD_BITS-1:0] HALF =
      (PROD_BITS'(1) << GAIN_FRAC_BITS) >> 1;
   localparam logic signed [PROD_BITS-1:0] MAXV =
      (PROD_BITS'(1) << (SAMPLE_BITS - 1)) - PROD_BITS'(1);
   localparam logic signed [PROD_BITS-1:0] MINV = -MAXV - PROD_BITS'(1);

   logic signed [PROD_BITS-1:0] rounded;
   logic signed [PROD_BITS-1:0] quot;

   assign rounded = product + HALF;
   assign quot    = rounded >>> GAIN_FRAC_BITS;

   always_comb begin
      saturated  = 1'b0;
      derivative = quot[SAMPLE_BITS-1:0];
      if (quot > MAXV) begin
         saturated  = 1'b1;
         derivative = MAXV[SAMPLE_BITS-1:0];
      end else if (quot < MINV) begin
         saturated  = 1'b1;
         derivative = MINV[SAMPLE_BITS-1:0];
      end
   end

endmodule

// ----- sv/stencil_derivative_filter_top.sv -----
// Stencil derivative filter: delay line, stencil sum, gain multiply, round and clip.
// Depends on sdf_pkg, sdf_stencil and sdf_round.
//
// One sample is taken per clock cycle while req_ready is high, and one derivative is
// returned for each after the stencil sum register, the gain multiplier register and
// the rounding/saturation output register. Back-pressure on the result side only
// stalls the stages that are full, so bubbles are squeezed out. The derivative refers
// to the sample two requests back; taps not yet filled after reset read as zero. The
// user must write method, order and gain through the csr port only while no request
// is in flight; the block itself does not enforce this.
module stencil_derivative_filter_top #(
   parameter int SAMPLE_BITS    = sdf_pkg::SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = sdf_pkg::GAIN_FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_BITS-1:0]        req_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]        rsp_derivative,
   output logic                                 rsp_saturated,
   input  logic                                 csr_wr_en,
   input  logic [sdf_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [sdf_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   localparam int SUM_BITS  = SAMPLE_BITS + sdf_pkg::STENCIL_GROWTH;
   localparam int PROD_BITS = SUM_BITS + sdf_pkg::GAIN_BITS;

   logic                                  method_ff;
   logic [sdf_pkg::ORDER_BITS-1:0]        order_ff;
   logic signed [sdf_pkg::GAIN_BITS-1:0]  gain_ff;
   sdf_pkg::stencil_cfg_type              cfg;

   logic                                  sum_valid_ff, sum_valid_in;
   logic                                  prod_valid_ff, prod_valid_in;
   logic                                  out_valid_ff, out_valid_in;
   logic signed [SUM_BITS-1:0]            sum_ff, sum_in;
   logic signed [PROD_BITS-1:0]           prod_ff, prod_in;
   logic signed [SAMPLE_BITS-1:0]         deriv_ff, deriv_in;
   logic                                  sat_ff, sat_in;

   logic req_fire, sum_adv, prod_adv, out_adv;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         method_ff <= sdf_pkg::METHOD_RESET;
         order_ff  <= sdf_pkg::ORDER_RESET;
         gain_ff   <= sdf_pkg::GAIN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            sdf_pkg::CSR_METHOD: method_ff <= csr_data[0];
            sdf_pkg::CSR_ORDER:  order_ff  <= csr_data[sdf_pkg::ORDER_BITS-1:0];
            sdf_pkg::CSR_GAIN:   gain_ff   <= csr_data[sdf_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.method = method_ff;
   assign cfg.order  = order_ff;

   // stage advance, each stage moves when empty or when its successor moves
   assign out_adv   = !out_valid_ff || rsp_ready;
   assign prod_adv  = !prod_valid_ff || out_adv;
   assign sum_adv   = !sum_valid_ff || prod_adv;
   assign req_ready = sum_adv;
   assign req_fire  = req_valid && req_ready;

   assign sum_valid_in  = sum_adv  ? req_fire      : sum_valid_ff;
   assign prod_valid_in = prod_adv ? sum_valid_ff  : prod_valid_ff;
   assign out_valid_in  = out_adv  ? prod_valid_ff : out_valid_ff;

   sdf_stencil #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .SUM_BITS    (SUM_BITS)
   ) u_stencil (
      .clock  (clock),
      .reset  (reset),
      .accept (req_fire),
      .sample (req_sample),
      .cfg    (cfg),
      .sum    (sum_in)
   );

   assign prod_in = PROD_BITS'(sum_ff) * PROD_BITS'(gain_ff);

   sdf_round #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .PROD_BITS      (PROD_BITS)
   ) u_round (
      .product    (prod_ff),
      .derivative (deriv_in),
      .saturated  (sat_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         sum_valid_ff  <= sum_valid_in;
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) sum_ff <= sum_in;
      if (prod_adv) prod_ff <= prod_in;
      if (out_adv) begin
         deriv_ff <= deriv_in;
         sat_ff   <= sat_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_derivative = deriv_ff;
   assign rsp_saturated  = sat_ff;

   localparam logic signed [SAMPLE_BITS-1:0] DMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] DMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   a_sat_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_saturated) |-> (rsp_derivative == DMAX || rsp_derivative == DMIN))
      else $error("saturated result not at a range limit");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (sum_valid_ff && prod_valid_ff && out_valid_ff))
      else $error("request stalled with an empty stage");

   a_sum_moves: assert property (@(posedge clock) disable iff (reset)
      (sum_valid_ff && prod_adv) |=> prod_valid_ff)
      else $error("stencil sum lost between stages");

endmodule
